// ----- rtl/core/pol_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pol_pkg - shared types for the positional ordered list
// Opcodes, status codes, the input and result words, and the per-cell
// control word broadcast along the cell chain.
// ----------------------------------------------------------------------------
package pol_pkg;

    // default number of list slots
    localparam int DEPTH_DEF = 32;

    // list operations
    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_READ   = 3'd2,
        OP_WRITE  = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    // result status
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // input word
    typedef struct packed {
        logic [2:0]         op;
        logic [5:0]         position;
        logic signed [31:0] data_value;
    } t_in_word;

    // result word
    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [5:0]         entry_count;
    } t_out_word;

    // control broadcast to every cell
    typedef struct packed {
        logic        shift_up;  // insert: cells above the slot take the left neighbor
        logic        shift_dn;  // remove: cells at/above the slot take the right neighbor
        logic        load;      // overwrite: the selected cell takes the value
        logic [31:0] value;     // value for insert or overwrite
    } t_cell_ctl;

endpackage

// ----- rtl/core/pol_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pol_cell - one list slot
// Holds one entry and moves it to or from its neighbors on insert and
// remove. Drives its entry onto the read tap when it is the selected slot.
// ----------------------------------------------------------------------------
module pol_cell
    import pol_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  logic                       i_clk,
    input  t_cell_ctl                  i_ctl,
    input  logic [$clog2(DEPTH)-1:0]   i_sel,
    input  logic [31:0]                i_left,
    input  logic [31:0]                i_right,
    output logic [31:0]                o_entry,
    output logic [31:0]                o_tap
);

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [31:0] r_entry;
    logic [31:0] n_entry;
    logic        hit;
    logic        above;

    assign hit   = (i_sel == MY_IDX);
    assign above = (MY_IDX > i_sel);

    // next entry: shift, load or hold
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift_up) begin
            if (above) begin
                n_entry = i_left;
            end else if (hit) begin
                n_entry = i_ctl.value;
            end
        end else if (i_ctl.shift_dn) begin
            if (above || hit) begin
                n_entry = i_right;
            end
        end else if (i_ctl.load && hit) begin
            n_entry = i_ctl.value;
        end
    end

    // entry register, no reset: contents are undefined until written
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_tap   = hit ? r_entry : 32'd0;

endmodule

// ----- rtl/core/positional_ordered_list_core.sv -----
`timescale 1ns / 1ps
// A result word is registered in the cycle after its input word is accepted.
// Throughput: one word per cycle unless output stalls; cells shift in parallel.
// A read selects one slot through an OR of the cell taps into the result register.
// Reset clears the entry count and the result valid; slot contents are not reset.
// ----------------------------------------------------------------------------
// positional_ordered_list_core - ordered list with positional insert/remove
// Decodes each word against the entry count, broadcasts shift/load control
// to a chain of slot cells and registers one result word per input word.
// ----------------------------------------------------------------------------
module positional_ordered_list_core
    import pol_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_word  i_in_word,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = ((CW > 6) ? CW : 6) + 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_out_word     r_out;

    logic          in_acc;
    logic [EW-1:0] pos_e;
    logic [EW-1:0] cnt_e;
    logic [IW-1:0] sel;
    t_status       st;
    logic          ins_ok;
    logic          rem_ok;
    logic          wr_ok;
    logic          rd_ok;
    logic [31:0]   tap_or;
    t_cell_ctl     ctl;

    logic [31:0] entry_q [DEPTH];
    logic [31:0] tap_q   [DEPTH];

    // handshake: a new word is taken whenever the result register can be refilled
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_acc     = i_in_valid & ~o_in_stall;

    assign pos_e = EW'(i_in_word.position);
    assign cnt_e = EW'(r_count);
    assign sel   = IW'(pos_e - EW'(1));

    // decode against the current count
    always_comb begin
        st      = ST_OK;
        ins_ok  = 1'b0;
        rem_ok  = 1'b0;
        wr_ok   = 1'b0;
        rd_ok   = 1'b0;
        n_count = r_count;
        case (i_in_word.op)
            OP_INSERT: begin
                if ((pos_e == '0) || (pos_e > cnt_e + EW'(1))) begin
                    st = ST_BADPOS;
                end else if (r_count == FULL_CNT) begin
                    st = ST_FULL;
                end else begin
                    ins_ok  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            OP_REMOVE, OP_READ, OP_WRITE: begin
                if (r_count == '0) begin
                    st = ST_EMPTY;
                end else if ((pos_e == '0) || (pos_e > cnt_e)) begin
                    st = ST_BADPOS;
                end else if (i_in_word.op == OP_REMOVE) begin
                    rem_ok  = 1'b1;
                    n_count = r_count - CW'(1);
                end else if (i_in_word.op == OP_READ) begin
                    rd_ok = 1'b1;
                end else begin
                    wr_ok = 1'b1;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                st = ST_OK;
            end
        endcase
    end

    // broadcast control, gated by acceptance
    always_comb begin
        ctl.shift_up = in_acc & ins_ok;
        ctl.shift_dn = in_acc & rem_ok;
        ctl.load     = in_acc & wr_ok;
        ctl.value    = $unsigned(i_in_word.data_value);
    end

    // the cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [31:0] left_w;
        logic [31:0] right_w;
        if (g == 0) begin : g_first
            assign left_w = entry_q[g];
        end else begin : g_mid
            assign left_w = entry_q[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_w = entry_q[g];
        end else begin : g_inner
            assign right_w = entry_q[g+1];
        end
        pol_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_sel   (sel),
            .i_left  (left_w),
            .i_right (right_w),
            .o_entry (entry_q[g]),
            .o_tap   (tap_q[g])
        );
    end

    // read: only the selected cell drives a nonzero tap
    always_comb begin
        tap_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            tap_or = tap_or | tap_q[i];
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_acc) begin
            r_count <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out.read_value  <= rd_ok ? $signed(tap_or) : 32'sd0;
            r_out.status      <= st;
            r_out.entry_count <= 6'(n_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above depth");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted word produced no result");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_word.op == OP_CLEAR)) |=> (r_count == '0))
        else $error("clear left entries");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && ins_ok) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (st == ST_FULL)) |-> (r_count == FULL_CNT))
        else $error("full status on a list with room");

endmodule
